FILE: rtl/core/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg: shared definitions for the calculator arithmetic unit
// Fixed-point format, saturation limits, operation and status codes.
// ----------------------------------------------------------------------------
package cau_pkg;

   // fixed-point format: signed, DATA_W bits, FRACTION_BITS below the point
   localparam int DATA_W        = 32;
   localparam int FRACTION_BITS = 16;
   localparam int EXPONENT_BITS = 16;

   // divider numerator holds |a| shifted up by the fraction bits
   localparam int NUM_W     = DATA_W + FRACTION_BITS;
   localparam int DIV_CNT_W = $clog2(NUM_W);

   localparam logic [DATA_W-1:0] FX_ONE  = DATA_W'(1) << FRACTION_BITS;
   localparam logic [DATA_W-1:0] SAT_MAX = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

   // limits of a full-width product after the fraction shift
   localparam logic signed [2*DATA_W-1:0] PROD_MAX = 64'sh0000_0000_7fff_ffff;
   localparam logic signed [2*DATA_W-1:0] PROD_MIN = 64'shffff_ffff_8000_0000;

   // largest exponent the power loop runs
   localparam logic signed [DATA_W-1:0] EXP_LIMIT =
      DATA_W'((64'd1 << EXPONENT_BITS) - 64'd1);

   // operation selector
   typedef enum logic [2:0] {
      ACT_ADD  = 3'd0,
      ACT_SUB  = 3'd1,
      ACT_MUL  = 3'd2,
      ACT_DIV  = 3'd3,
      ACT_POW  = 3'd4,
      ACT_FACT = 3'd5
   } action_type;

   // result status
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DIV_ZERO = 2'd1,
      ST_NEG_FACT = 2'd2,
      ST_BAD_ACT  = 2'd3
   } status_type;

endpackage

FILE: rtl/core/calculator_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calculator_arithmetic_unit: fixed-point alu with divide, power, factorial
// Q16.16 add, subtract, multiply and divide with saturation, integer power
// by square-and-multiply and factorial modulo 2^32, on one shared multiplier
// and a radix-2 divider under a small sequencer.
//
//   channel  | dir | tdata (low bit up)                        | tuser
//   ---------+-----+-------------------------------------------+--------------
//   req_     | in  | operand_a, operand_b, count_operand       | action
//   rsp_     | out | value, factorial_value                    | status
//
// one word in flight; req_tready is high only while the sequencer is idle
// add/subtract finish in the start state, multiply in S_MUL then S_WB, and
// divide gives one quotient bit a cycle; power squares per exponent bit and
// multiplies once more per set bit; factorial runs one multiply per step of the running product
// a finished result sits in the output register until taken; the next word
//   is accepted meanwhile, and a result waits in its final state if needed
// reset is synchronous active high and clears the sequencer and rsp_tvalid
// ----------------------------------------------------------------------------
module calculator_arithmetic_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // operand_a, operand_b, count_operand
   input  logic [2:0]  req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // value, factorial_value
   output logic [1:0]  rsp_tuser    // status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_MUL,
      S_WB,
      S_PSTEP,
      S_FSTEP,
      S_DIV,
      S_DONE
   } state_type;

   // which product the shared multiplier forms
   typedef enum logic [1:0] {
      MS_MUL,
      MS_ACC,
      MS_SQ,
      MS_FACT
   } mul_sel_type;

   localparam int DW = cau_pkg::DATA_W;
   localparam int FB = cau_pkg::FRACTION_BITS;
   localparam int NW = cau_pkg::NUM_W;

   state_type                           state_ff,   state_in;
   mul_sel_type                         mul_sel_ff, mul_sel_in;
   cau_pkg::action_type                 op_ff,      op_in;
   logic signed [DW-1:0]                a_ff,       a_in;
   logic signed [DW-1:0]                b_ff,       b_in;
   logic signed [7:0]                   n_ff,       n_in;
   logic signed [DW-1:0]                acc_ff,     acc_in;
   logic signed [DW-1:0]                sq_ff,      sq_in;
   logic [cau_pkg::EXPONENT_BITS-1:0]   e_ff,       e_in;
   logic [DW-1:0]                       fact_ff,    fact_in;
   logic [7:0]                          idx_ff,     idx_in;
   logic [DW-1:0]                       rem_ff,     rem_in;
   logic [NW-1:0]                       num_ff,     num_in;
   logic [DW-1:0]                       dvs_ff,     dvs_in;
   logic                                neg_ff,     neg_in;
   logic [cau_pkg::DIV_CNT_W-1:0]       cnt_ff,     cnt_in;
   logic signed [2*DW-1:0]              prod_ff,    prod_in;
   logic [DW-1:0]                       val_ff,     val_in;
   cau_pkg::status_type                 stat_ff,    stat_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [63:0]                         rsp_data_ff,  rsp_data_in;
   cau_pkg::status_type                 rsp_user_ff,  rsp_user_in;

   logic                                req_accept;
   logic signed [DW-1:0]                mul_x, mul_y;
   logic signed [2*DW-1:0]              product;
   logic signed [2*DW-1:0]              prod_shift;
   logic [DW-1:0]                       prod_sat;
   logic signed [DW:0]                  sum_wide, dif_wide;
   logic [DW-1:0]                       abs_a, abs_b;
   logic signed [DW-1:0]                e_int;
   logic [DW:0]                         div_shift, div_sub;
   logic                                div_ge;
   logic [DW-1:0]                       div_sat;

   // saturate a sum that grew by one bit
   function automatic logic [DW-1:0] sat_wide(input logic signed [DW:0] v);
      logic [DW-1:0] r;
      if (v[DW] != v[DW-1]) begin
         r = v[DW] ? cau_pkg::SAT_MIN : cau_pkg::SAT_MAX;
      end else begin
         r = v[DW-1:0];
      end
      return r;
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // shared multiplier operand select
   always_comb begin
      unique case (mul_sel_ff)
         MS_MUL: begin
            mul_x = a_ff;
            mul_y = b_ff;
         end
         MS_ACC: begin
            mul_x = acc_ff;
            mul_y = sq_ff;
         end
         MS_SQ: begin
            mul_x = sq_ff;
            mul_y = sq_ff;
         end
         MS_FACT: begin
            mul_x = $signed(fact_ff);
            mul_y = $signed(DW'(idx_ff));
         end
         default: begin
            mul_x = a_ff;
            mul_y = b_ff;
         end
      endcase
   end

   assign product = mul_x * mul_y;

   // product back to fixed point: floor shift, then saturate
   assign prod_shift = prod_ff >>> FB;
   always_comb begin
      if (prod_shift > cau_pkg::PROD_MAX) begin
         prod_sat = cau_pkg::SAT_MAX;
      end else if (prod_shift < cau_pkg::PROD_MIN) begin
         prod_sat = cau_pkg::SAT_MIN;
      end else begin
         prod_sat = prod_shift[DW-1:0];
      end
   end

   // add and subtract with one guard bit
   assign sum_wide = {a_ff[DW-1], a_ff} + {b_ff[DW-1], b_ff};
   assign dif_wide = {a_ff[DW-1], a_ff} - {b_ff[DW-1], b_ff};

   // magnitudes for the divider, integer part of the exponent
   assign abs_a = a_ff[DW-1] ? DW'(-a_ff) : DW'(a_ff);
   assign abs_b = b_ff[DW-1] ? DW'(-b_ff) : DW'(b_ff);
   assign e_int = b_ff >>> FB;

   // one restoring divide step
   assign div_shift = {rem_ff, num_ff[NW-1]};
   assign div_ge    = (div_shift >= {1'b0, dvs_ff});
   assign div_sub   = div_shift - {1'b0, dvs_ff};

   // signed, saturated quotient from the magnitude in num_ff
   always_comb begin
      if (neg_ff) begin
         if (num_ff > NW'(cau_pkg::SAT_MIN)) begin
            div_sat = cau_pkg::SAT_MIN;
         end else begin
            div_sat = DW'(-num_ff[DW-1:0]);
         end
      end else begin
         if (num_ff > NW'(cau_pkg::SAT_MAX)) begin
            div_sat = cau_pkg::SAT_MAX;
         end else begin
            div_sat = num_ff[DW-1:0];
         end
      end
   end

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      mul_sel_in   = mul_sel_ff;
      op_in        = op_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      n_in         = n_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      e_in         = e_ff;
      fact_in      = fact_ff;
      idx_in       = idx_ff;
      rem_in       = rem_ff;
      num_in       = num_ff;
      dvs_in       = dvs_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      val_in       = val_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      // result taken downstream
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in    = cau_pkg::action_type'(req_tuser);
               a_in     = $signed(req_tdata[31:0]);
               b_in     = $signed(req_tdata[63:32]);
               n_in     = $signed(req_tdata[71:64]);
               state_in = S_START;
            end
         end

         S_START: begin
            val_in  = '0;
            fact_in = '0;
            stat_in = cau_pkg::ST_OK;
            unique case (op_ff)
               cau_pkg::ACT_ADD: begin
                  val_in   = sat_wide(sum_wide);
                  state_in = S_DONE;
               end
               cau_pkg::ACT_SUB: begin
                  val_in   = sat_wide(dif_wide);
                  state_in = S_DONE;
               end
               cau_pkg::ACT_MUL: begin
                  mul_sel_in = MS_MUL;
                  state_in   = S_MUL;
               end
               cau_pkg::ACT_DIV: begin
                  if (b_ff == '0) begin
                     stat_in  = cau_pkg::ST_DIV_ZERO;
                     state_in = S_DONE;
                  end else begin
                     rem_in   = '0;
                     num_in   = {abs_a, FB'(0)};
                     dvs_in   = abs_b;
                     neg_in   = a_ff[DW-1] ^ b_ff[DW-1];
                     cnt_in   = '0;
                     state_in = S_DIV;
                  end
               end
               cau_pkg::ACT_POW: begin
                  if (e_int < DW'(1)) begin
                     val_in   = cau_pkg::FX_ONE;
                     state_in = S_DONE;
                  end else begin
                     if (e_int > cau_pkg::EXP_LIMIT) begin
                        e_in = '1;
                     end else begin
                        e_in = e_int[cau_pkg::EXPONENT_BITS-1:0];
                     end
                     acc_in   = cau_pkg::FX_ONE;
                     sq_in    = a_ff;
                     state_in = S_PSTEP;
                  end
               end
               cau_pkg::ACT_FACT: begin
                  if (n_ff[7]) begin
                     stat_in  = cau_pkg::ST_NEG_FACT;
                     state_in = S_DONE;
                  end else begin
                     fact_in  = DW'(1);
                     idx_in   = 8'd1;
                     state_in = S_FSTEP;
                  end
               end
               default: begin
                  stat_in  = cau_pkg::ST_BAD_ACT;
                  state_in = S_DONE;
               end
            endcase
         end

         // multiplier cycle, product registered
         S_MUL: begin
            prod_in  = product;
            state_in = S_WB;
         end

         // write back the registered product
         S_WB: begin
            unique case (mul_sel_ff)
               MS_MUL: begin
                  val_in   = prod_sat;
                  state_in = S_DONE;
               end
               MS_ACC: begin
                  acc_in     = prod_sat;
                  mul_sel_in = MS_SQ;
                  state_in   = S_MUL;
               end
               MS_SQ: begin
                  sq_in    = prod_sat;
                  e_in     = e_ff >> 1;
                  state_in = S_PSTEP;
               end
               MS_FACT: begin
                  fact_in  = prod_ff[DW-1:0];
                  idx_in   = idx_ff + 8'd1;
                  state_in = S_FSTEP;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         // next exponent bit, stop once no set bits remain
         S_PSTEP: begin
            if (e_ff == '0) begin
               val_in   = acc_ff;
               state_in = S_DONE;
            end else begin
               mul_sel_in = e_ff[0] ? MS_ACC : MS_SQ;
               state_in   = S_MUL;
            end
         end

         // next factor of the running product
         S_FSTEP: begin
            if (idx_ff > 8'(n_ff)) begin
               state_in = S_DONE;
            end else begin
               mul_sel_in = MS_FACT;
               state_in   = S_MUL;
            end
         end

         // one quotient bit per cycle
         S_DIV: begin
            rem_in = div_ge ? div_sub[DW-1:0] : div_shift[DW-1:0];
            num_in = {num_ff[NW-2:0], div_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == cau_pkg::DIV_CNT_W'(NW - 1)) begin
               state_in = S_DONE;
            end
         end

         // load the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               if (op_ff == cau_pkg::ACT_DIV && stat_ff == cau_pkg::ST_OK) begin
                  rsp_data_in = {fact_ff, div_sat};
               end else begin
                  rsp_data_in = {fact_ff, val_ff};
               end
               rsp_user_in  = stat_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mul_sel_ff   <= MS_MUL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mul_sel_ff   <= mul_sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      n_ff        <= n_in;
      acc_ff      <= acc_in;
      sq_ff       <= sq_in;
      e_ff        <= e_in;
      fact_ff     <= fact_in;
      idx_ff      <= idx_in;
      rem_ff      <= rem_in;
      num_ff      <= num_in;
      dvs_ff      <= dvs_in;
      neg_ff      <= neg_in;
      cnt_ff      <= cnt_in;
      prod_ff     <= prod_in;
      val_ff      <= val_in;
      stat_ff     <= stat_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // an accepted word always starts the sequencer
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == S_START)
      else $error("accepted word did not start the sequencer");

   // divider remainder stays below the divisor
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> rem_ff < dvs_ff)
      else $error("divider remainder not below divisor");

   // factorial index never passes n + 1
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FSTEP |-> idx_ff <= 8'(n_ff) + 8'd1)
      else $error("factorial index overran");

   // error results carry zero data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_user_ff != cau_pkg::ST_OK |-> rsp_data_ff == '0)
      else $error("error result with nonzero data");

   // a new result only comes from the final state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside the final state");

endmodule

FILE: tb/calculator_arithmetic_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calculator_arithmetic_unit_test: self-checking bench for the q16.16 alu
// A directed table covers the format extremes, every operation and the error
// codes. About 1800 random words follow, mostly well-formed operands per
// operation. Every word accepted on req_ gets a typed or predicted result.
// Each rsp_ word is checked field by field against the oldest pending result.
// Both channels idle in random bursts, with a calm tail at the end.
// ----------------------------------------------------------------------------
module calculator_arithmetic_unit_test;

   // spare selector codes with no operation behind them
   localparam logic [2:0] ACT_UNUSED_A = 3'd6;
   localparam logic [2:0] ACT_UNUSED_B = 3'd7;

   localparam longint WORD_MAX       = 64'sd2147483647;
   localparam longint WORD_MIN       = -64'sd2147483648;
   localparam int     RANDOM_ITEMS   = 1800;
   localparam int     CALM_ITEMS     = 150;
   localparam int     WATCHDOG_LIMIT = 4000;
   localparam int     DRAIN_CYCLES   = 400;

   // handy q16.16 constants
   localparam logic signed [31:0] FX_TWO       = 32'sh0002_0000;
   localparam logic signed [31:0] FX_THREE     = 32'sh0003_0000;
   localparam logic signed [31:0] FX_SEVEN     = 32'sh0007_0000;
   localparam logic signed [31:0] FX_HALF      = 32'sh0000_8000;
   localparam logic signed [31:0] FX_NEG_ONE   = 32'shffff_0000;
   localparam logic signed [31:0] FX_NEG_1P5   = 32'shfffe_8000;
   localparam logic signed [31:0] FX_3P5       = 32'sh0003_8000;
   localparam logic signed [31:0] FX_NEG_SEVEN = 32'shfff9_0000;

   typedef struct packed {
      logic signed [31:0] value;
      logic signed [31:0] fact_value;
      logic [1:0]         status;
   } result_type;

   typedef struct {
      logic [2:0]         action;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
      logic signed [7:0]  count;
      bit                 typed;
      result_type         want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;   // operand_a, operand_b, count_operand
   logic [2:0]  req_tuser;   // action
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // value, factorial_value
   logic [1:0]  rsp_tuser;   // status

   result_type   pending_results[$];
   stim_row_type directed_rows[$];
   int           mismatch_count = 0;
   int           quiet_cycles   = 0;
   bit           calm_tail      = 1'b0;

   calculator_arithmetic_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic logic signed [31:0] clamp_word(input longint v);
      if (v > WORD_MAX) return cau_pkg::SAT_MAX;
      if (v < WORD_MIN) return cau_pkg::SAT_MIN;
      return v[31:0];
   endfunction

   // full product, low fraction bits dropped (floor), then saturated
   function automatic logic signed [31:0] fx_product(input logic signed [31:0] x,
                                                     input logic signed [31:0] y);
      longint p;
      p = longint'(x) * longint'(y);
      return clamp_word(p >>> cau_pkg::FRACTION_BITS);
   endfunction

   function automatic result_type alu_result(input logic [2:0]         act,
                                             input logic signed [31:0] a,
                                             input logic signed [31:0] b,
                                             input logic signed [7:0]  n);
      result_type         r;
      longint             expo;
      logic signed [31:0] acc;
      logic signed [31:0] sq;
      logic [31:0]        prod;
      r = '0;
      case (act)
         cau_pkg::ACT_ADD: r.value = clamp_word(longint'(a) + longint'(b));
         cau_pkg::ACT_SUB: r.value = clamp_word(longint'(a) - longint'(b));
         cau_pkg::ACT_MUL: r.value = fx_product(a, b);
         cau_pkg::ACT_DIV: begin
            if (b == 0) r.status = cau_pkg::ST_DIV_ZERO;
            else r.value = clamp_word((longint'(a) <<< cau_pkg::FRACTION_BITS) / longint'(b));
         end
         cau_pkg::ACT_POW: begin
            // integer part of the exponent, floor for negatives
            expo = longint'(b) >>> cau_pkg::FRACTION_BITS;
            if (expo < 1) begin
               r.value = cau_pkg::FX_ONE;
            end else begin
               if (expo > longint'(cau_pkg::EXP_LIMIT)) expo = longint'(cau_pkg::EXP_LIMIT);
               acc = cau_pkg::FX_ONE;
               sq  = a;
               for (int i = 0; i < cau_pkg::EXPONENT_BITS; i++) begin
                  if (expo[i]) acc = fx_product(acc, sq);
                  sq = fx_product(sq, sq);
               end
               r.value = acc;
            end
         end
         cau_pkg::ACT_FACT: begin
            if (n < 0) begin
               r.status = cau_pkg::ST_NEG_FACT;
            end else begin
               prod = 32'd1;
               for (int i = 1; i <= int'(n); i++) prod = prod * 32'(i);
               r.fact_value = prod;
            end
         end
         default: r.status = cau_pkg::ST_BAD_ACT;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers
   function automatic void add_row(input logic [2:0] act, input logic signed [31:0] a,
                                   input logic signed [31:0] b, input logic signed [7:0] n,
                                   input bit typed, input logic signed [31:0] want_value,
                                   input logic signed [31:0] want_fact,
                                   input cau_pkg::status_type want_status);
      stim_row_type row;
      row.action            = act;
      row.operand_a         = a;
      row.operand_b         = b;
      row.count             = n;
      row.typed             = typed;
      row.want.value        = want_value;
      row.want.fact_value   = want_fact;
      row.want.status       = want_status;
      directed_rows.push_back(row);
   endfunction

   function automatic logic signed [31:0] pick_operand();
      logic signed [31:0] v;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: v = $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
         2: begin
            case ($urandom_range(0, 6))
               0: v = cau_pkg::SAT_MAX;
               1: v = cau_pkg::SAT_MIN;
               2: v = 32'sd0;
               3: v = cau_pkg::FX_ONE;
               4: v = FX_NEG_ONE;
               5: v = 32'sd1;
               default: v = -32'sd1;
            endcase
         end
         default: v = ($signed($urandom_range(0, 400)) - 200) <<< cau_pkg::FRACTION_BITS;
      endcase
      return v;
   endfunction

   task automatic send_word(input logic [2:0] act, input logic signed [31:0] a,
                            input logic signed [31:0] b, input logic signed [7:0] n);
      req_tuser  <= act;
      req_tdata  <= {n, b, a};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // random idle burst on the request side, none in the calm tail
   task automatic pause_between();
      if (!calm_tail && ($urandom_range(0, 1) == 1)) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // ---------------------------------------------------------------- request driver
   initial begin
      stim_row_type       row;
      logic [2:0]         act;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [7:0]  n;
      int                 pick;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= cau_pkg::ACT_ADD;

      // format extremes and error codes typed in, the rest predicted
      add_row(cau_pkg::ACT_ADD, 32'sd0, 32'sd0, 8'sd0,
              1'b1, 32'sd0, 32'sd0, cau_pkg::ST_OK);
      add_row(cau_pkg::ACT_ADD, cau_pkg::SAT_MAX, cau_pkg::SAT_MAX, 8'sd0,
              1'b1, cau_pkg::SAT_MAX, 32'sd0, cau_pkg::ST_OK);
      add_row(cau_pkg::ACT_ADD, cau_pkg::SAT_MIN, cau_pkg::SAT_MIN, 8'sd0,
              1'b1, cau_pkg::SAT_MIN, 32'sd0, cau_pkg::ST_OK);
      add_row(cau_pkg::ACT_ADD, FX_NEG_1P5, FX_THREE, 8'sd3,
              1'b0, 32'sd0, 32'sd0, cau_pkg::ST_OK);
      add_row(cau_pkg::ACT_SUB, cau_pkg::SAT_MIN, cau_pkg::SAT_MAX, 8'sd0,
              1'b1, cau_pkg::SAT_MIN, 32'sd0, cau_pkg::ST_OK);
      add_row(cau_pkg::ACT_SUB, 32'sd0, cau_pkg::SAT_MIN, 8'sd0,
              1'b1, cau_pkg::SAT_MAX, 32'sd0, cau_pkg::ST_OK);
      add_row(cau_pkg::ACT_MUL, cau_pkg::FX_ONE, cau_pkg::FX_ONE, 8'sd0,
              1'b1, cau_pkg::FX_ONE, 32'sd0, cau_pkg::ST_OK);
      add_row(cau_pkg::ACT_MUL, cau_pkg::SAT_MAX, cau_pkg::SAT_MAX, 8'sd0,
              1'b1, cau_pkg::SAT_MAX, 32'sd0, cau_pkg::ST_OK);
      add_row(cau_pkg::ACT_MUL, cau_pkg::SAT_MIN, cau_pkg::SAT_MAX, 8'sd0,
              1'b1, cau_pkg::SAT_MIN, 32'sd0, cau_pkg::ST_OK);
      add_row(cau_pkg::ACT_MUL, -32'sd1, 32'sd1, 8'sd0,
              1'b1, -32'sd1, 32'sd0, cau_pkg::ST_OK);
      add_row(cau_pkg::ACT_DIV, cau_pkg::FX_ONE, 32'sd0, 8'sd0,
              1'b1, 32'sd0, 32'sd0, cau_pkg::ST_DIV_ZERO);
      add_row(cau_pkg::ACT_DIV, cau_pkg::SAT_MIN, -32'sd1, 8'sd0,
              1'b1, cau_pkg::SAT_MAX, 32'sd0, cau_pkg::ST_OK);
      add_row(cau_pkg::ACT_DIV, cau_pkg::FX_ONE, FX_THREE, 8'sd0,
              1'b0, 32'sd0, 32'sd0, cau_pkg::ST_OK);
      add_row(cau_pkg::ACT_DIV, FX_NEG_SEVEN, FX_TWO, 8'sd0,
              1'b0, 32'sd0, 32'sd0, cau_pkg::ST_OK);
      add_row(cau_pkg::ACT_POW, FX_TWO, 32'sd0, 8'sd0,
              1'b1, cau_pkg::FX_ONE, 32'sd0, cau_pkg::ST_OK);
      add_row(cau_pkg::ACT_POW, FX_TWO, cau_pkg::SAT_MIN, 8'sd0,
              1'b1, cau_pkg::FX_ONE, 32'sd0, cau_pkg::ST_OK);
      add_row(cau_pkg::ACT_POW, FX_SEVEN, FX_HALF, 8'sd0,
              1'b1, cau_pkg::FX_ONE, 32'sd0, cau_pkg::ST_OK);
      add_row(cau_pkg::ACT_POW, FX_TWO, FX_3P5, 8'sd0,
              1'b0, 32'sd0, 32'sd0, cau_pkg::ST_OK);
      add_row(cau_pkg::ACT_POW, cau_pkg::SAT_MAX, cau_pkg::SAT_MAX, 8'sd0,
              1'b0, 32'sd0, 32'sd0, cau_pkg::ST_OK);
      add_row(cau_pkg::ACT_POW, FX_NEG_1P5, cau_pkg::SAT_MAX, 8'sd0,
              1'b0, 32'sd0, 32'sd0, cau_pkg::ST_OK);
      add_row(cau_pkg::ACT_POW, cau_pkg::SAT_MIN, FX_TWO, 8'sd0,
              1'b0, 32'sd0, 32'sd0, cau_pkg::ST_OK);
      add_row(cau_pkg::ACT_FACT, 32'sd0, 32'sd0, 8'sd0,
              1'b1, 32'sd0, 32'sd1, cau_pkg::ST_OK);
      add_row(cau_pkg::ACT_FACT, cau_pkg::SAT_MAX, cau_pkg::SAT_MIN, 8'sd1,
              1'b1, 32'sd0, 32'sd1, cau_pkg::ST_OK);
      add_row(cau_pkg::ACT_FACT, 32'sd0, 32'sd0, -8'sd1,
              1'b1, 32'sd0, 32'sd0, cau_pkg::ST_NEG_FACT);
      add_row(cau_pkg::ACT_FACT, 32'sd0, 32'sd0, -8'sd128,
              1'b1, 32'sd0, 32'sd0, cau_pkg::ST_NEG_FACT);
      add_row(cau_pkg::ACT_FACT, 32'sd0, 32'sd0, 8'sd127,
              1'b0, 32'sd0, 32'sd0, cau_pkg::ST_OK);
      add_row(ACT_UNUSED_A, cau_pkg::SAT_MAX, cau_pkg::SAT_MIN, 8'sd5,
              1'b1, 32'sd0, 32'sd0, cau_pkg::ST_BAD_ACT);
      add_row(ACT_UNUSED_B, cau_pkg::FX_ONE, FX_TWO, -8'sd7,
              1'b1, 32'sd0, 32'sd0, cau_pkg::ST_BAD_ACT);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         pause_between();
         send_word(row.action, row.operand_a, row.operand_b, row.count);
         if (row.typed) pending_results.push_back(row.want);
         else pending_results.push_back(alu_result(row.action, row.operand_a,
                                                   row.operand_b, row.count));
      end

      // random words, weighted toward the multi-cycle operations
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k >= RANDOM_ITEMS - CALM_ITEMS) calm_tail = 1'b1;
         pick = $urandom_range(0, 15);
         a    = pick_operand();
         b    = pick_operand();
         n    = 8'($urandom);
         if (pick < 2) act = cau_pkg::ACT_ADD;
         else if (pick < 4) act = cau_pkg::ACT_SUB;
         else if (pick < 7) act = cau_pkg::ACT_MUL;
         else if (pick < 10) begin
            act = cau_pkg::ACT_DIV;
            if ($urandom_range(0, 7) == 0) b = 32'sd0;
         end else if (pick < 13) begin
            act = cau_pkg::ACT_POW;
            // keep most bases near unity so the loop does not just saturate
            case ($urandom_range(0, 2))
               0: a = pick_operand();
               1: begin
                  a = cau_pkg::FX_ONE + $signed($urandom_range(0, 32'h2000)) - 32'sh1000;
                  if ($urandom_range(0, 1) == 1) a = -a;
               end
               default: a = $signed($urandom_range(0, 32'h0004_0000)) - FX_TWO;
            endcase
            case ($urandom_range(0, 3))
               0: b = pick_operand();
               1: b = -$signed($urandom_range(0, 32'h0004_0000));
               default: b = ($signed($urandom_range(0, 24)) <<< cau_pkg::FRACTION_BITS)
                            | $signed($urandom_range(0, 16'hffff));
            endcase
         end else if (pick < 15) begin
            act = cau_pkg::ACT_FACT;
            if ($urandom_range(0, 1) == 1) n = 8'($urandom_range(0, 20));
         end else begin
            act = ($urandom_range(0, 1) == 1) ? ACT_UNUSED_A : ACT_UNUSED_B;
         end
         pause_between();
         send_word(act, a, b, n);
         pending_results.push_back(alu_result(act, a, b, n));
      end
      req_tvalid <= 1'b0;

      // drain, then give the sequencer time to show any stray word
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("** calculator_arithmetic_unit: PASSED **");
      end else begin
         $display("** calculator_arithmetic_unit: FAILED **");
      end
      $finish;
   end

   // ---------------------------------------------------------------- response backpressure
   initial begin
      rsp_tready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (calm_tail || ($urandom_range(0, 2) != 0)) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------- result checker and watchdog
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.value      = rsp_tdata[31:0];
            got.fact_value = rsp_tdata[63:32];
            got.status     = rsp_tuser;
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected word: value %h fact %h status %0d",
                           got.value, got.fact_value, got.status);
            end else begin
               want = pending_results.pop_front();
               if (got.value !== want.value || got.fact_value !== want.fact_value ||
                   got.status !== want.status) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: want %h/%h/%0d got %h/%h/%0d (value/fact/status)",
                              want.value, want.fact_value, want.status,
                              got.value, got.fact_value, got.status);
               end
            end
         end
         // watchdog on cycles where neither channel moves a word
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved in %0d cycles", WATCHDOG_LIMIT);
            $display("** calculator_arithmetic_unit: FAILED **");
            $finish;
         end
      end
   end

endmodule

FILE: calculator_arithmetic_unit.f
rtl/core/cau_pkg.sv
rtl/core/calculator_arithmetic_unit.sv
tb/calculator_arithmetic_unit_test.sv
